@@ src/utf8_hiragana_to_katakana_assert.svh @@
// Assertion macros used by the converter back end (clock i_clk, reset i_rst_n).
`ifndef UTF8_HIRAGANA_TO_KATAKANA_ASSERT_SVH
`define UTF8_HIRAGANA_TO_KATAKANA_ASSERT_SVH

// Condition holds at every edge out of reset.
`define UHK_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("assertion failed");

// Consequent holds in the same cycle as the antecedent.
`define UHK_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent holds in the cycle after the antecedent.
`define UHK_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/uhk_pkg.sv @@
// Shared types and constants of the hiragana-to-katakana UTF-8 converter.
package uhk_pkg;

    localparam int QDEPTH_DEF = 4;

    localparam logic [15:0] HIRA_FIRST  = 16'h3041;
    localparam logic [15:0] HIRA_LAST   = 16'h3096;
    localparam logic [15:0] KATA_OFFSET = 16'h0060;

    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_VAL  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_VAL  = 8'hE0;
    localparam logic [7:0] CONT_BASE  = 8'h80;

    localparam logic [1:0] RUN_ONE   = 2'd1;
    localparam logic [1:0] RUN_TWO   = 2'd2;
    localparam logic [1:0] RUN_THREE = 2'd3;

    // One step's worth of output: up to three bytes sent in order.
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] cnt;
        logic       text_end;
    } t_run;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

@@ src/utf8_hiragana_to_katakana.sv @@
// Top level of the hiragana-to-katakana UTF-8 byte stream converter.
//
// Input channel: one text byte per beat (i_in_byte, i_in_last marks the final
// byte of the text), i_in_valid / o_in_stall. Output channel: one byte per
// beat (o_out_byte), o_out_run_last on the last byte caused by one input beat,
// o_out_text_end on the last byte of the text, o_out_valid / i_out_stall.
// Hiragana U+3041..U+3096 come out as katakana; every other byte is passed
// through, so output byte count equals input byte count.
// Throughput: one byte per cycle in and out, sustained while i_out_stall is
// low. Lead bytes are held (no output) and the group comes out once complete.
// The run of a beat that completes a group goes from the front into the run
// queue and from there into the output run register, whose bytes then leave
// in order.
// A stalled receiver holds the output run register; the run queue (QDEPTH
// runs) keeps absorbing input until full, then o_in_stall rises.
// Reset (synchronous, active low) drops pending lead bytes, empties the queue
// and clears the output valid.
module utf8_hiragana_to_katakana
    import uhk_pkg::*;
#(
    parameter int QDEPTH = QDEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_run_last,
    output logic       o_out_text_end
);

    t_q_status q_status;
    t_run      push_run;
    t_run      head;
    logic      push;
    logic      pop;

    // classification and code point conversion
    uhk_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .i_q_status (q_status),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_push_run (push_run)
    );

    // decouples the two sides; one entry per producing input beat
    uhk_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_run (push_run),
        .i_pop      (pop),
        .o_head     (head),
        .o_status   (q_status)
    );

    // byte serializer with output register
    uhk_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_q_status     (q_status),
        .i_out_stall    (i_out_stall),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .o_out_byte     (o_out_byte),
        .o_out_run_last (o_out_run_last),
        .o_out_text_end (o_out_text_end)
    );

endmodule

@@ src/uhk_front.sv @@
// Front end: takes input beats, tracks pending lead bytes, builds output runs.
module uhk_front
    import uhk_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    input  t_q_status  i_q_status,
    output logic       o_in_stall,
    output logic       o_push,
    output t_run       o_push_run
);

    logic [7:0] r_held0, n_held0;
    logic [7:0] r_held1, n_held1;
    logic [1:0] r_cnt, n_cnt;
    logic       r_three, n_three;

    logic        acc;
    logic        lead2;
    logic        lead3;
    logic        produce;
    logic [15:0] cp;
    logic [15:0] cp_kata;
    t_run        run;

    assign o_in_stall = i_q_status.full;
    assign acc        = i_in_valid && !o_in_stall;

    assign lead2   = (i_in_byte & LEAD2_MASK) == LEAD2_VAL;
    assign lead3   = (i_in_byte & LEAD3_MASK) == LEAD3_VAL;
    assign cp      = {r_held0[3:0], r_held1[5:0], i_in_byte[5:0]};
    assign cp_kata = cp + KATA_OFFSET;

    always_comb begin
        n_held0  = r_held0;
        n_held1  = r_held1;
        n_cnt    = r_cnt;
        n_three  = r_three;
        produce  = 1'b0;
        run      = '0;
        run.text_end = i_in_last;
        if (r_cnt == 2'd0) begin
            if ((lead2 || lead3) && !i_in_last) begin
                n_held0 = i_in_byte;
                n_cnt   = 2'd1;
                n_three = lead3;
            end else begin
                produce = 1'b1;
                run.b0  = i_in_byte;
                run.cnt = RUN_ONE;
            end
        end else if (!r_three) begin
            // two-byte group: copied as is
            produce = 1'b1;
            run.b0  = r_held0;
            run.b1  = i_in_byte;
            run.cnt = RUN_TWO;
            n_cnt   = 2'd0;
        end else if (r_cnt == 2'd1) begin
            if (i_in_last) begin
                // three-byte group cut short by end of text
                produce = 1'b1;
                run.b0  = r_held0;
                run.b1  = i_in_byte;
                run.cnt = RUN_TWO;
                n_cnt   = 2'd0;
                n_three = 1'b0;
            end else begin
                n_held1 = i_in_byte;
                n_cnt   = 2'd2;
            end
        end else begin
            produce = 1'b1;
            run.cnt = RUN_THREE;
            if (cp >= HIRA_FIRST && cp <= HIRA_LAST) begin
                run.b0 = LEAD3_VAL | {4'd0, cp_kata[15:12]};
                run.b1 = CONT_BASE | {2'd0, cp_kata[11:6]};
                run.b2 = CONT_BASE | {2'd0, cp_kata[5:0]};
            end else begin
                run.b0 = r_held0;
                run.b1 = r_held1;
                run.b2 = i_in_byte;
            end
            n_cnt   = 2'd0;
            n_three = 1'b0;
        end
    end

    assign o_push     = acc && produce;
    assign o_push_run = run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= 2'd0;
            r_three <= 1'b0;
        end else if (acc) begin
            r_cnt   <= n_cnt;
            r_three <= n_three;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_held0 <= n_held0;
            r_held1 <= n_held1;
        end
    end

endmodule

@@ src/uhk_queue.sv @@
// Run queue between front and back end.
module uhk_queue
    import uhk_pkg::*;
#(
    parameter int DEPTH = QDEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_run      i_push_run,
    input  logic      i_pop,
    output t_run      o_head,
    output t_q_status o_status
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_run          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_status.full  = r_count == CW'(DEPTH);
    assign o_status.empty = r_count == '0;
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ src/uhk_back.sv @@
// Back end: serializes queued runs into output beats, one byte per beat.
module uhk_back
    import uhk_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_run       i_head,
    input  t_q_status  i_q_status,
    input  logic       i_out_stall,
    output logic       o_pop,
    output logic       o_out_valid,
    output logic [7:0] o_out_byte,
    output logic       o_out_run_last,
    output logic       o_out_text_end
);

`include "utf8_hiragana_to_katakana_assert.svh"

    logic       r_busy;
    t_run       r_run;
    logic [1:0] r_idx;

    logic run_last;
    logic beat;
    logic done;

    assign run_last = r_idx == (r_run.cnt - 2'd1);
    assign beat     = r_busy && !i_out_stall;
    assign done     = beat && run_last;
    // reload in the cycle the last byte leaves, so runs follow without a gap
    assign o_pop    = !i_q_status.empty && (!r_busy || done);

    always_comb begin
        case (r_idx)
            2'd0:    o_out_byte = r_run.b0;
            2'd1:    o_out_byte = r_run.b1;
            default: o_out_byte = r_run.b2;
        endcase
    end

    assign o_out_valid    = r_busy;
    assign o_out_run_last = run_last;
    assign o_out_text_end = run_last && r_run.text_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (done) begin
            r_busy <= 1'b0;
        end else if (beat) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_run <= i_head;
        end
    end

    `UHK_ASSERT_IMPLY(a_run_nonempty, r_busy, r_run.cnt != 2'd0)
    `UHK_ASSERT_IMPLY(a_idx_in_run, r_busy, r_idx < r_run.cnt)
    `UHK_ASSERT_NEXT(a_seamless_reload, done && !i_q_status.empty, r_busy && r_idx == 2'd0)

endmodule
